FILE: design/tcm_pkg.sv
package tcm_pkg;

   localparam int POINT_COUNT = 5;

   localparam logic [2:0] PT_A       = 3'd0;
   localparam logic [2:0] PT_B       = 3'd1;
   localparam logic [2:0] PT_C       = 3'd2;
   localparam logic [2:0] PT_D       = 3'd3;
   localparam logic [2:0] PT_E       = 3'd4;
   localparam logic [2:0] LAST_POINT = PT_E;
   localparam logic [2:0] NUM_POINTS = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_OFF   = 2'd1;
   localparam logic [1:0] ST_CALIB = 2'd2;
   localparam logic [1:0] ST_FAIL  = 2'd3;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam logic [11:0] WIDTH_RESET  = 12'd480;
   localparam logic [11:0] HEIGHT_RESET = 12'd272;

   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_EVAL,
      S_SUMS,
      S_CHECK,
      S_DIVX_GO,
      S_DIVX_WAIT,
      S_DIVY_GO,
      S_DIVY_WAIT,
      S_MUL_X,
      S_ACC_X,
      S_FIN_X,
      S_MUL_Y,
      S_ACC_Y,
      S_FIN_Y,
      S_OUT_CAL,
      S_OUT_FAIL,
      S_OUT_MAP
   } state_type;

   typedef enum logic [1:0] {
      RES_CALIB,
      RES_FAIL,
      RES_MAP
   } res_kind_type;

   typedef struct packed {
      logic         load_req;
      logic         restart;
      logic         hold;
      logic         capture;
      logic         sums;
      logic         div_start;
      logic         axis;
      logic         gain_store;
      logic         commit;
      logic         mul;
      logic         acc;
      logic         fin;
      logic         out_load;
      res_kind_type out_kind;
   } cmd_type;

   typedef struct packed {
      logic action;
      logic run_mode;
      logic pressure_nz;
      logic pen_down;
      logic last_point;
      logic den_zero;
      logic div_done;
      logic out_free;
   } stat_type;

endpackage

FILE: design/touch_calibrate_and_map.sv
// Channel   Direction  Handshake              Payload
// req_*     in         req_valid / req_stall  action, raw_x, raw_y, pressure
// rsp_*     out        rsp_valid / rsp_stall  status, screen x/y, pressure, target x/y/index
// csr_*     in         csr_valid / csr_ready  index (0 width, 1 height), 12-bit data
//
// A calibrating or restart sample passes only evaluation before the result register;
// a run-mode sample first passes multiply, then accumulate and round, per axis, on one shared multiplier.
// On the fifth capture, unless a span sum is zero, the bit-serial divider first computes
// both gains in turn. The next request is taken in the cycle after the result loads.
// No clearing pass follows reset; csr_ready is always high.
// A new request is taken while an earlier result still waits behind rsp_stall.
module touch_calibrate_and_map
   import tcm_pkg::*;
#(
   parameter int RAW_BITS       = 10,
   parameter int GAIN_FRAC_BITS = 16,
   parameter int TARGET_MARGIN  = 50
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic [RAW_BITS-1:0] req_raw_x,
   input  logic [RAW_BITS-1:0] req_raw_y,
   input  logic [7:0]          req_pressure,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [11:0]         rsp_screen_x,
   output logic [11:0]         rsp_screen_y,
   output logic [7:0]          rsp_pressure_out,
   output logic [11:0]         rsp_target_x,
   output logic [11:0]         rsp_target_y,
   output logic [2:0]          rsp_target_index,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [11:0]         csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   tcm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   tcm_datapath #(
      .RAW_BITS      (RAW_BITS),
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
      .TARGET_MARGIN (TARGET_MARGIN)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_action      (req_action),
      .req_raw_x       (req_raw_x),
      .req_raw_y       (req_raw_y),
      .req_pressure    (req_pressure),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_screen_y    (rsp_screen_y),
      .rsp_pressure_out(rsp_pressure_out),
      .rsp_target_x    (rsp_target_x),
      .rsp_target_y    (rsp_target_y),
      .rsp_target_index(rsp_target_index)
   );

endmodule

FILE: design/tcm_divider.sv
module tcm_divider
   import tcm_pkg::*;
#(
   parameter int NUM_BITS = 29,
   parameter int DEN_BITS = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic [NUM_BITS-1:0] quo,
   output logic                done
);

   localparam int CNT_BITS = $clog2(NUM_BITS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;

   logic [DEN_BITS:0]   shifted;
   logic [DEN_BITS:0]   trial;
   logic                fits;

   // Restoring division, one quotient bit per cycle. The remainder stays below
   // the divisor, so the shifted remainder needs only one extra bit.
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_BITS-1]};
      fits    = shifted >= {1'b0, den};
      trial   = shifted - {1'b0, den};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
         quo_in = {quo_ff[NUM_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(NUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

FILE: design/tcm_ctrl.sv
module tcm_ctrl
   import tcm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EVAL;
         end
         S_EVAL: begin
            priority if (stat.action) state_in = S_OUT_CAL;
            else if (stat.run_mode) state_in = S_MUL_X;
            else if (stat.pressure_nz) state_in = S_OUT_CAL;
            else if (stat.pen_down && stat.last_point) state_in = S_SUMS;
            else state_in = S_OUT_CAL;
         end
         S_SUMS:    state_in = S_CHECK;
         S_CHECK: begin
            state_in = stat.den_zero ? S_OUT_FAIL : S_DIVX_GO;
         end
         S_DIVX_GO: state_in = S_DIVX_WAIT;
         S_DIVX_WAIT: begin
            if (stat.div_done) state_in = S_DIVY_GO;
         end
         S_DIVY_GO: state_in = S_DIVY_WAIT;
         S_DIVY_WAIT: begin
            if (stat.div_done) state_in = S_OUT_CAL;
         end
         S_MUL_X:   state_in = S_ACC_X;
         S_ACC_X:   state_in = S_FIN_X;
         S_FIN_X:   state_in = S_MUL_Y;
         S_MUL_Y:   state_in = S_ACC_Y;
         S_ACC_Y:   state_in = S_FIN_Y;
         S_FIN_Y:   state_in = S_OUT_MAP;
         S_OUT_CAL, S_OUT_FAIL, S_OUT_MAP: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.out_kind = RES_CALIB;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_req = req_valid;
         end
         S_EVAL: begin
            priority if (stat.action) cmd.restart = 1'b1;
            else if (stat.run_mode) cmd.capture = 1'b0;
            else if (stat.pressure_nz) cmd.hold = 1'b1;
            else if (stat.pen_down) cmd.capture = 1'b1;
            else cmd.hold = 1'b0;
         end
         S_SUMS: begin
            cmd.sums = 1'b1;
         end
         S_CHECK: begin
            cmd.restart = stat.den_zero;
         end
         S_DIVX_GO: begin
            cmd.div_start = 1'b1;
            cmd.axis      = AXIS_X;
         end
         S_DIVX_WAIT: begin
            cmd.axis       = AXIS_X;
            cmd.gain_store = stat.div_done;
         end
         S_DIVY_GO: begin
            cmd.div_start = 1'b1;
            cmd.axis      = AXIS_Y;
         end
         S_DIVY_WAIT: begin
            cmd.axis       = AXIS_Y;
            cmd.gain_store = stat.div_done;
            cmd.commit     = stat.div_done;
         end
         S_MUL_X: begin
            cmd.mul  = 1'b1;
            cmd.axis = AXIS_X;
         end
         S_ACC_X: begin
            cmd.acc  = 1'b1;
            cmd.axis = AXIS_X;
         end
         S_FIN_X: begin
            cmd.fin  = 1'b1;
            cmd.axis = AXIS_X;
         end
         S_MUL_Y: begin
            cmd.mul  = 1'b1;
            cmd.axis = AXIS_Y;
         end
         S_ACC_Y: begin
            cmd.acc  = 1'b1;
            cmd.axis = AXIS_Y;
         end
         S_FIN_Y: begin
            cmd.fin  = 1'b1;
            cmd.axis = AXIS_Y;
         end
         S_OUT_CAL: begin
            cmd.out_load = stat.out_free;
            cmd.out_kind = RES_CALIB;
         end
         S_OUT_FAIL: begin
            cmd.out_load = stat.out_free;
            cmd.out_kind = RES_FAIL;
         end
         S_OUT_MAP: begin
            cmd.out_load = stat.out_free;
            cmd.out_kind = RES_MAP;
         end
         default: begin
            cmd.load_req = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   a_accept_evaluates: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_EVAL))
      else $error("accepted transaction was not evaluated");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("result loaded over an unaccepted result");

   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (state_ff == S_DIVX_WAIT || state_ff == S_DIVY_WAIT))
      else $error("divider finished outside a wait state");

   a_last_capture_calibrates: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && stat.last_point) |=> (state_ff == S_SUMS))
      else $error("fifth capture did not start calibration");

endmodule

FILE: design/tcm_datapath.sv
module tcm_datapath
   import tcm_pkg::*;
#(
   parameter int RAW_BITS       = 10,
   parameter int GAIN_FRAC_BITS = 16,
   parameter int TARGET_MARGIN  = 50
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic                csr_valid,
   input  logic                csr_index,
   input  logic [11:0]         csr_data,
   input  logic                req_action,
   input  logic [RAW_BITS-1:0] req_raw_x,
   input  logic [RAW_BITS-1:0] req_raw_y,
   input  logic [7:0]          req_pressure,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [11:0]         rsp_screen_x,
   output logic [11:0]         rsp_screen_y,
   output logic [7:0]          rsp_pressure_out,
   output logic [11:0]         rsp_target_x,
   output logic [11:0]         rsp_target_y,
   output logic [2:0]          rsp_target_index
);

   localparam int GAIN_BITS = 7 + GAIN_FRAC_BITS;
   localparam int LIM_BIT   = GAIN_BITS - 1;
   localparam int SUM_BITS  = RAW_BITS + 2;
   localparam int DEN_BITS  = RAW_BITS + 1;
   localparam int NUM_BITS  = 13 + GAIN_FRAC_BITS;
   localparam int DIFF_BITS = RAW_BITS + 1;
   localparam int PROD_BITS = GAIN_BITS + DIFF_BITS;
   localparam int ACC_BITS  = PROD_BITS + 1;
   localparam int MAP_BITS  = ACC_BITS - GAIN_FRAC_BITS;
   localparam int PT_BITS   = 2 * RAW_BITS;

   localparam logic [11:0] MARGIN   = 12'(TARGET_MARGIN);
   localparam logic [13:0] SPAN_SUB = 14'(2 * TARGET_MARGIN);

   // Configuration registers.
   logic [11:0] width_ff, width_in;
   logic [11:0] height_ff, height_in;

   // Latched request transaction.
   logic                act_ff;
   logic [RAW_BITS-1:0] rx_ff, ry_ff;
   logic [7:0]          pr_ff;

   // Calibration state.
   logic [PT_BITS-1:0]         pts_ff [POINT_COUNT];
   logic [PT_BITS-1:0]         held_ff, held_in;
   logic                       pen_ff, pen_in;
   logic [2:0]                 idx_ff, idx_in;
   logic                       swap_ff, swap_in;
   logic [PT_BITS-1:0]         centre_ff, centre_in;
   logic signed [GAIN_BITS-1:0] gain_ff [2];
   logic signed [SUM_BITS-1:0] dxs_ff, dys_ff;
   logic                       swap_cand_ff;

   // Mapping pipeline.
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [ACC_BITS-1:0]  acc_ff;
   logic                        map_ok_ff [2];
   logic [11:0]                 map_val_ff [2];

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic [11:0] rsp_sx_ff, rsp_sy_ff, rsp_tx_ff, rsp_ty_ff;
   logic [7:0]  rsp_po_ff;
   logic [2:0]  rsp_idx_ff;

   function automatic logic signed [SUM_BITS-1:0] span_sum(
      input logic [RAW_BITS-1:0] a,
      input logic [RAW_BITS-1:0] b,
      input logic [RAW_BITS-1:0] c,
      input logic [RAW_BITS-1:0] d
   );
      logic signed [SUM_BITS-1:0] ab;
      logic signed [SUM_BITS-1:0] cd;
      ab = $signed(SUM_BITS'(a)) - $signed(SUM_BITS'(b));
      cd = $signed(SUM_BITS'(c)) - $signed(SUM_BITS'(d));
      return ab + cd;
   endfunction

   // ---------------------------------------------------------------
   // Calibration arithmetic
   // ---------------------------------------------------------------
   logic [RAW_BITS-1:0] px [POINT_COUNT];
   logic [RAW_BITS-1:0] py [POINT_COUNT];
   logic signed [RAW_BITS:0] d_bax, d_bay;
   logic [RAW_BITS:0]        abs_bax, abs_bay;
   logic                     swap_det;
   logic signed [SUM_BITS-1:0] dxs_n, dys_n, dxs_s, dys_s;

   always_comb begin
      for (int i = 0; i < POINT_COUNT; i++) begin
         px[i] = pts_ff[i][RAW_BITS-1:0];
         py[i] = pts_ff[i][PT_BITS-1:RAW_BITS];
      end
      d_bax    = $signed({1'b0, px[1]}) - $signed({1'b0, px[0]});
      d_bay    = $signed({1'b0, py[1]}) - $signed({1'b0, py[0]});
      abs_bax  = d_bax[RAW_BITS] ? $unsigned(-d_bax) : $unsigned(d_bax);
      abs_bay  = d_bay[RAW_BITS] ? $unsigned(-d_bay) : $unsigned(d_bay);
      // The axes count as swapped unless A to B moves more in x than in y.
      swap_det = !(abs_bax > abs_bay);
      dxs_n    = span_sum(px[1], px[0], px[2], px[3]);
      dys_n    = span_sum(py[3], py[0], py[2], py[1]);
      dxs_s    = span_sum(py[1], py[0], py[2], py[3]);
      dys_s    = span_sum(px[3], px[0], px[2], px[1]);
   end

   logic [11:0]                res_sel;
   logic signed [SUM_BITS-1:0] den_sel;
   logic [SUM_BITS-1:0]        den_abs;
   logic signed [13:0]         span;
   logic [13:0]                span_abs;
   logic [NUM_BITS-1:0]        div_num;
   logic                       q_neg;
   logic [NUM_BITS-1:0]        quo;
   logic                       div_done;
   logic                       over_pos, over_neg;
   logic signed [GAIN_BITS-1:0] gain_q;

   always_comb begin
      res_sel  = (cmd.axis == AXIS_Y) ? height_ff : width_ff;
      den_sel  = (cmd.axis == AXIS_Y) ? dys_ff : dxs_ff;
      den_abs  = den_sel[SUM_BITS-1] ? $unsigned(-den_sel) : $unsigned(den_sel);
      span     = $signed({2'b00, res_sel}) - $signed(SPAN_SUB);
      span_abs = span[13] ? $unsigned(-span) : $unsigned(span);
      div_num  = {span_abs[11:0], 1'b0, {GAIN_FRAC_BITS{1'b0}}};
      q_neg    = span[13] ^ den_sel[SUM_BITS-1];
      over_pos = |quo[NUM_BITS-1:LIM_BIT];
      over_neg = (|quo[NUM_BITS-1:LIM_BIT+1]) | (quo[LIM_BIT] & (|quo[LIM_BIT-1:0]));
      if (!q_neg) begin
         gain_q = over_pos ? $signed({1'b0, {LIM_BIT{1'b1}}})
                           : $signed(quo[GAIN_BITS-1:0]);
      end else begin
         gain_q = over_neg ? $signed({1'b1, {LIM_BIT{1'b0}}})
                           : -$signed(quo[GAIN_BITS-1:0]);
      end
   end

   tcm_divider #(
      .NUM_BITS(NUM_BITS),
      .DEN_BITS(DEN_BITS)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .start(cmd.div_start),
      .num  (div_num),
      .den  (den_abs[DEN_BITS-1:0]),
      .quo  (quo),
      .done (div_done)
   );

   // ---------------------------------------------------------------
   // Mapping arithmetic
   // ---------------------------------------------------------------
   logic [RAW_BITS-1:0]         samp_sel, cen_sel;
   logic signed [DIFF_BITS-1:0] diff;
   logic signed [GAIN_BITS-1:0] gain_sel;
   logic signed [PROD_BITS-1:0] prod_in;
   logic [ACC_BITS-1:0]         offset;
   logic signed [ACC_BITS-1:0]  acc_in;
   logic signed [ACC_BITS-1:0]  bias;
   logic signed [ACC_BITS-1:0]  trunc_sum;
   logic signed [MAP_BITS-1:0]  map_val;
   logic                        map_ok;
   logic                        out_ok;

   always_comb begin
      if (cmd.axis == AXIS_Y) begin
         samp_sel = swap_ff ? rx_ff : ry_ff;
         cen_sel  = centre_ff[PT_BITS-1:RAW_BITS];
      end else begin
         samp_sel = swap_ff ? ry_ff : rx_ff;
         cen_sel  = centre_ff[RAW_BITS-1:0];
      end
      diff     = $signed({1'b0, samp_sel}) - $signed({1'b0, cen_sel});
      gain_sel = gain_ff[cmd.axis];
      prod_in  = gain_sel * diff;
      offset   = ACC_BITS'({res_sel[11:1], {GAIN_FRAC_BITS{1'b0}}});
      acc_in   = $signed(ACC_BITS'(prod_ff)) + $signed(offset);
      // Adding 2^F-1 to a negative value before the arithmetic shift rounds
      // toward zero.
      bias      = acc_ff[ACC_BITS-1] ? $signed(ACC_BITS'({GAIN_FRAC_BITS{1'b1}})) : '0;
      trunc_sum = acc_ff + bias;
      map_val   = trunc_sum[ACC_BITS-1:GAIN_FRAC_BITS];
      map_ok    = !map_val[MAP_BITS-1] && ($unsigned(map_val) < MAP_BITS'(res_sel));
      out_ok    = (cmd.out_kind == RES_MAP) && map_ok_ff[0] && map_ok_ff[1];
   end

   // ---------------------------------------------------------------
   // Targets
   // ---------------------------------------------------------------
   logic [11:0] tgt_x, tgt_y;

   always_comb begin
      unique case (idx_ff)
         PT_A: begin
            tgt_x = MARGIN;
            tgt_y = MARGIN;
         end
         PT_B: begin
            tgt_x = width_ff - MARGIN;
            tgt_y = MARGIN;
         end
         PT_C: begin
            tgt_x = width_ff - MARGIN;
            tgt_y = height_ff - MARGIN;
         end
         PT_D: begin
            tgt_x = MARGIN;
            tgt_y = height_ff - MARGIN;
         end
         PT_E: begin
            tgt_x = {1'b0, width_ff[11:1]};
            tgt_y = {1'b0, height_ff[11:1]};
         end
         default: begin
            tgt_x = '0;
            tgt_y = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // State update
   // ---------------------------------------------------------------
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH:  width_in  = csr_data;
            CSR_HEIGHT: height_in = csr_data;
            default:    width_in  = width_ff;
         endcase
      end

      held_in   = held_ff;
      pen_in    = pen_ff;
      idx_in    = idx_ff;
      swap_in   = swap_ff;
      centre_in = centre_ff;
      priority if (cmd.restart) begin
         held_in = '0;
         pen_in  = 1'b0;
         idx_in  = PT_A;
         swap_in = 1'b0;
      end else if (cmd.hold) begin
         held_in = {ry_ff, rx_ff};
         pen_in  = 1'b1;
      end else if (cmd.capture) begin
         pen_in = 1'b0;
         idx_in = idx_ff + 3'd1;
      end else if (cmd.commit) begin
         swap_in   = swap_cand_ff;
         centre_in = swap_cand_ff ? {px[PT_E], py[PT_E]} : {py[PT_E], px[PT_E]};
      end

      rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         held_ff      <= '0;
         pen_ff       <= 1'b0;
         idx_ff       <= PT_A;
         swap_ff      <= 1'b0;
         centre_ff    <= '0;
         gain_ff[0]   <= '0;
         gain_ff[1]   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         held_ff      <= held_in;
         pen_ff       <= pen_in;
         idx_ff       <= idx_in;
         swap_ff      <= swap_in;
         centre_ff    <= centre_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.gain_store) gain_ff[cmd.axis] <= gain_q;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff <= req_action;
         rx_ff  <= req_raw_x;
         ry_ff  <= req_raw_y;
         pr_ff  <= req_pressure;
      end
      if (cmd.capture) pts_ff[idx_ff] <= held_ff;
      if (cmd.sums) begin
         swap_cand_ff <= swap_det;
         dxs_ff       <= swap_det ? dxs_s : dxs_n;
         dys_ff       <= swap_det ? dys_s : dys_n;
      end
      if (cmd.mul) prod_ff <= prod_in;
      if (cmd.acc) acc_ff <= acc_in;
      if (cmd.fin) begin
         map_ok_ff[cmd.axis]  <= map_ok;
         map_val_ff[cmd.axis] <= map_val[11:0];
      end
      if (cmd.out_load) begin
         rsp_tx_ff  <= tgt_x;
         rsp_ty_ff  <= tgt_y;
         rsp_idx_ff <= idx_ff;
         rsp_sx_ff  <= out_ok ? map_val_ff[0] : '0;
         rsp_sy_ff  <= out_ok ? map_val_ff[1] : '0;
         rsp_po_ff  <= out_ok ? pr_ff : '0;
         unique case (cmd.out_kind)
            RES_CALIB: rsp_status_ff <= ST_CALIB;
            RES_FAIL:  rsp_status_ff <= ST_FAIL;
            RES_MAP:   rsp_status_ff <= out_ok ? ST_OK : ST_OFF;
            default:   rsp_status_ff <= ST_CALIB;
         endcase
      end
   end

   always_comb begin
      stat.action      = act_ff;
      stat.run_mode    = (idx_ff == NUM_POINTS);
      stat.pressure_nz = |pr_ff;
      stat.pen_down    = pen_ff;
      stat.last_point  = (idx_ff == LAST_POINT);
      stat.den_zero    = (dxs_ff == '0) || (dys_ff == '0);
      stat.div_done    = div_done;
      stat.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_screen_x     = rsp_sx_ff;
   assign rsp_screen_y     = rsp_sy_ff;
   assign rsp_pressure_out = rsp_po_ff;
   assign rsp_target_x     = rsp_tx_ff;
   assign rsp_target_y     = rsp_ty_ff;
   assign rsp_target_index = rsp_idx_ff;

   a_capture_advances: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (idx_ff == $past(idx_ff) + 3'd1) && !pen_ff)
      else $error("capture did not advance the point index");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |-> (idx_ff <= NUM_POINTS))
      else $error("point index out of range");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

FILE: verif/tb_touch_calibrate_and_map.sv
module tb_touch_calibrate_and_map
   import tcm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RAW_W       = 10;
   localparam int GAIN_FRAC   = 16;
   localparam int MARGIN      = 50;
   localparam int RAW_MAX     = (1 << RAW_W) - 1;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE_WAIT = 80;
   localparam int QUIET_LIMIT = 5000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 58;

   localparam logic ACT_SAMPLE  = 1'b0;
   localparam logic ACT_RESTART = 1'b1;

   typedef struct packed {
      logic       action;
      logic [9:0] raw_x;
      logic [9:0] raw_y;
      logic [7:0] pressure;
   } touch_sample_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] screen_x;
      logic [11:0] screen_y;
      logic [7:0]  pressure_out;
      logic [11:0] target_x;
      logic [11:0] target_y;
      logic [2:0]  target_index;
   } touch_report_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_action       = ACT_SAMPLE;
   logic [9:0]  req_raw_x        = '0;
   logic [9:0]  req_raw_y        = '0;
   logic [7:0]  req_pressure     = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_screen_x;
   logic [11:0] rsp_screen_y;
   logic [7:0]  rsp_pressure_out;
   logic [11:0] rsp_target_x;
   logic [11:0] rsp_target_y;
   logic [2:0]  rsp_target_index;
   logic        csr_valid        = 1'b0;
   logic        csr_ready;
   logic        csr_index        = CSR_WIDTH;
   logic [11:0] csr_data         = '0;

   touch_calibrate_and_map uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_raw_x        (req_raw_x),
      .req_raw_y        (req_raw_y),
      .req_pressure     (req_pressure),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_screen_x     (rsp_screen_x),
      .rsp_screen_y     (rsp_screen_y),
      .rsp_pressure_out (rsp_pressure_out),
      .rsp_target_x     (rsp_target_x),
      .rsp_target_y     (rsp_target_y),
      .rsp_target_index (rsp_target_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Calibration state as the block should hold it.
   logic [19:0] cal_points [POINT_COUNT];
   logic [19:0] held_pt       = '0;
   logic        pen_down_seen = 1'b0;
   logic [2:0]  cal_index     = PT_A;
   logic        swap_xy       = 1'b0;
   longint      gain_x_q      = 0;
   longint      gain_y_q      = 0;
   logic [19:0] centre_pt     = '0;
   logic [11:0] scr_w         = WIDTH_RESET;
   logic [11:0] scr_h         = HEIGHT_RESET;

   touch_sample_type touch_q [$];
   touch_report_type outcome_q [$];
   touch_sample_type offered;

   int          touches_made   = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          hold_trigger   = 0;
   int          hold_served    = 0;
   int          hold_left      = 0;
   int          quiet_cycles   = 0;
   int unsigned fault_count    = 0;

   function automatic longint raw_x_of(input logic [19:0] p);
      return longint'(p[9:0]);
   endfunction

   function automatic longint raw_y_of(input logic [19:0] p);
      return longint'(p[19:10]);
   endfunction

   function automatic logic [19:0] swap_point(input logic [19:0] p);
      return {p[9:0], p[19:10]};
   endfunction

   function automatic longint gain_of(input longint span, input longint den);
      longint lim;
      longint g;
      lim = longint'(1) << (GAIN_FRAC + 6);
      g = (2 * span * (longint'(1) << GAIN_FRAC)) / den;
      if (g > lim - 1) g = lim - 1;
      if (g < -lim) g = -lim;
      return g;
   endfunction

   function automatic longint map_axis(input longint gain, input longint raw,
                                       input longint centre, input longint res);
      longint acc;
      acc = gain * (raw - centre) + (res / 2) * (longint'(1) << GAIN_FRAC);
      if (acc < 0) return -((-acc) >>> GAIN_FRAC);
      return acc >>> GAIN_FRAC;
   endfunction

   function automatic void restart_capture();
      cal_index     = PT_A;
      held_pt       = '0;
      pen_down_seen = 1'b0;
      swap_xy       = 1'b0;
   endfunction

   function automatic touch_report_type calibrate_and_map(input touch_sample_type t);
      touch_report_type r;
      logic [19:0]      pts [POINT_COUNT];
      logic [19:0]      raw;
      longint           dx_ab, dy_ab, x_sum, y_sum, mx, my, w, h, tx, ty;
      int               i;
      r = '0;
      r.status = ST_CALIB;
      raw = {t.raw_y, t.raw_x};
      w = longint'(scr_w);
      h = longint'(scr_h);
      if (t.action == ACT_RESTART) begin
         restart_capture();
      end else if (cal_index < NUM_POINTS) begin
         if (t.pressure != 8'd0) begin
            held_pt = raw;
            pen_down_seen = 1'b1;
         end else if (pen_down_seen) begin
            pen_down_seen = 1'b0;
            cal_points[cal_index] = held_pt;
            cal_index = cal_index + 3'd1;
            if (cal_index == NUM_POINTS) begin
               for (i = 0; i < POINT_COUNT; i++) pts[i] = cal_points[i];
               dx_ab = raw_x_of(pts[PT_B]) - raw_x_of(pts[PT_A]);
               dy_ab = raw_y_of(pts[PT_B]) - raw_y_of(pts[PT_A]);
               if (dx_ab < 0) dx_ab = -dx_ab;
               if (dy_ab < 0) dy_ab = -dy_ab;
               // The panel counts as rotated unless the A to B move is mostly along x.
               swap_xy = !(dx_ab > dy_ab);
               if (swap_xy) begin
                  for (i = 0; i < POINT_COUNT; i++) pts[i] = swap_point(pts[i]);
               end
               x_sum = (raw_x_of(pts[PT_B]) - raw_x_of(pts[PT_A]))
                     + (raw_x_of(pts[PT_C]) - raw_x_of(pts[PT_D]));
               y_sum = (raw_y_of(pts[PT_D]) - raw_y_of(pts[PT_A]))
                     + (raw_y_of(pts[PT_C]) - raw_y_of(pts[PT_B]));
               if (x_sum == 0 || y_sum == 0) begin
                  restart_capture();
                  r.status = ST_FAIL;
               end else begin
                  gain_x_q  = gain_of(w - 2 * MARGIN, x_sum);
                  gain_y_q  = gain_of(h - 2 * MARGIN, y_sum);
                  centre_pt = pts[PT_E];
               end
            end
         end
      end else begin
         if (swap_xy) raw = swap_point(raw);
         mx = map_axis(gain_x_q, raw_x_of(raw), raw_x_of(centre_pt), w);
         my = map_axis(gain_y_q, raw_y_of(raw), raw_y_of(centre_pt), h);
         if (mx < 0 || mx >= w || my < 0 || my >= h) begin
            r.status = ST_OFF;
         end else begin
            r.status       = ST_OK;
            r.screen_x     = mx[11:0];
            r.screen_y     = my[11:0];
            r.pressure_out = t.pressure;
         end
      end
      if (cal_index < NUM_POINTS) begin
         case (cal_index)
            PT_A: begin
               tx = MARGIN;
               ty = MARGIN;
            end
            PT_B: begin
               tx = w - MARGIN;
               ty = MARGIN;
            end
            PT_C: begin
               tx = w - MARGIN;
               ty = h - MARGIN;
            end
            PT_D: begin
               tx = MARGIN;
               ty = h - MARGIN;
            end
            default: begin
               tx = w / 2;
               ty = h / 2;
            end
         endcase
         r.target_x = tx[11:0];
         r.target_y = ty[11:0];
      end
      r.target_index = cal_index;
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      fault_count++;
   endtask

   function automatic int clamp_raw(input int v);
      return (v < 0) ? 0 : (v > RAW_MAX) ? RAW_MAX : v;
   endfunction

   task automatic push_touch(input logic act, input int x, input int y, input int p);
      touch_sample_type t;
      t.action   = act;
      t.raw_x    = x[9:0];
      t.raw_y    = y[9:0];
      t.pressure = p[7:0];
      touch_q.push_back(t);
      touches_made++;
   endtask

   // One or more pen-down samples near the target, then a pen-up that captures the last one.
   task automatic tap_target(input int x, input int y, input int jit);
      int presses;
      int k;
      int dx;
      int dy;
      presses = (jit == 0) ? 1 : $urandom_range(1, 3);
      for (k = 0; k < presses; k++) begin
         dx = $urandom_range(0, 2 * jit);
         dy = $urandom_range(0, 2 * jit);
         push_touch(ACT_SAMPLE, clamp_raw(x + dx - jit), clamp_raw(y + dy - jit),
                    $urandom_range(1, 255));
      end
      push_touch(ACT_SAMPLE, $urandom_range(0, RAW_MAX), $urandom_range(0, RAW_MAX), 0);
   endtask

   task automatic write_reg(input logic idx, input logic [11:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_WIDTH) scr_w = value;
      else scr_h = value;
   endtask

   // Driver: the prediction is made at the edge where the block takes the transaction.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            outcome_q.push_back(calibrate_and_map(offered));
         end
         if (!req_valid || !req_stall) begin
            if (touch_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered = touch_q.pop_front();
               req_valid    <= 1'b1;
               req_action   <= offered.action;
               req_raw_x    <= offered.raw_x;
               req_raw_y    <= offered.raw_y;
               req_pressure <= offered.pressure;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall, with an occasional long hold-off so that the block backs up.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_trigger) begin
         rsp_stall   <= 1'b1;
         hold_served <= hold_trigger;
         hold_left   <= LONG_HOLD;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      touch_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_q.size() == 0) begin
            flag_mismatch("unexpected transaction status", longint'(rsp_status), longint'(0));
         end else begin
            want = outcome_q.pop_front();
            if (rsp_status !== want.status)
               flag_mismatch("status", longint'(rsp_status), longint'(want.status));
            if (rsp_screen_x !== want.screen_x)
               flag_mismatch("screen_x", longint'(rsp_screen_x), longint'(want.screen_x));
            if (rsp_screen_y !== want.screen_y)
               flag_mismatch("screen_y", longint'(rsp_screen_y), longint'(want.screen_y));
            if (rsp_pressure_out !== want.pressure_out)
               flag_mismatch("pressure_out", longint'(rsp_pressure_out),
                             longint'(want.pressure_out));
            if (rsp_target_x !== want.target_x)
               flag_mismatch("target_x", longint'(rsp_target_x), longint'(want.target_x));
            if (rsp_target_y !== want.target_y)
               flag_mismatch("target_y", longint'(rsp_target_y), longint'(want.target_y));
            if (rsp_target_index !== want.target_index)
               flag_mismatch("target_index", longint'(rsp_target_index),
                             longint'(want.target_index));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_touch_calibrate_and_map NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [11:0] phase_w [PHASES];
      logic [11:0] phase_h [PHASES];
      logic [11:0] w, h;
      int          p, i, k, start, pick, jit, tmp;
      int          xlo, xhi, ylo, yhi;
      int          ax [POINT_COUNT];
      int          ay [POINT_COUNT];
      logic        flip_axes;
      // A zero entry stands for a random resolution.
      phase_w = '{WIDTH_RESET, 12'd101, 12'd4095, 12'd800, 12'd4095, 12'd0, 12'd101, 12'd0};
      phase_h = '{HEIGHT_RESET, 12'd101, 12'd4095, 12'd480, 12'd101, 12'd0, 12'd4095, 12'd0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            w = (phase_w[p] == 12'd0) ? 12'($urandom_range(101, 4095)) : phase_w[p];
            h = (phase_h[p] == 12'd0) ? 12'($urandom_range(101, 4095)) : phase_h[p];
            write_reg(CSR_WIDTH, w);
            write_reg(CSR_HEIGHT, h);
         end
         case (p % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 62;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 62;
               hold_trigger++;
            end
            default: begin
               send_idle_pct  = 12;
               recv_stall_pct = 12;
            end
         endcase

         if (p == 0) begin
            push_touch(ACT_RESTART, RAW_MAX, RAW_MAX, 255);
            // A pen-up with no pen-down before it captures nothing.
            push_touch(ACT_SAMPLE, 0, 0, 0);
            // Five identical points leave both span sums at zero.
            for (i = 0; i < POINT_COUNT; i++) tap_target(512, 512, 0);
            tap_target(100, 120, 0);
            tap_target(900, 130, 0);
            tap_target(910, 880, 0);
            tap_target(90, 890, 0);
            tap_target(505, 500, 0);
            push_touch(ACT_SAMPLE, 0, 0, 0);
            push_touch(ACT_SAMPLE, RAW_MAX, RAW_MAX, 255);
            push_touch(ACT_SAMPLE, 505, 500, 1);
         end

         start = touches_made;
         while (touches_made - start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            xlo = $urandom_range(0, 350);
            xhi = $urandom_range(650, RAW_MAX);
            ylo = $urandom_range(0, 350);
            yhi = $urandom_range(650, RAW_MAX);
            if ($urandom_range(0, 3) == 0) begin
               tmp = xlo;
               xlo = xhi;
               xhi = tmp;
            end
            if ($urandom_range(0, 3) == 0) begin
               tmp = ylo;
               ylo = yhi;
               yhi = tmp;
            end
            // Collapsing one axis makes its span sum zero and the calibration fail.
            if (pick < 8) xhi = xlo;
            else if (pick < 14) yhi = ylo;
            ax = '{xlo, xhi, xhi, xlo, (xlo + xhi) / 2};
            ay = '{ylo, ylo, yhi, yhi, (ylo + yhi) / 2};
            if (pick >= 90) begin
               for (i = 0; i < POINT_COUNT; i++) begin
                  ax[i] = $urandom_range(0, RAW_MAX);
                  ay[i] = $urandom_range(0, RAW_MAX);
               end
            end
            jit = (pick < 14) ? 0 : $urandom_range(0, 8);
            flip_axes = ($urandom_range(0, 3) == 0);
            push_touch(ACT_RESTART, $urandom_range(0, RAW_MAX), $urandom_range(0, RAW_MAX),
                       $urandom_range(0, 255));
            for (i = 0; i < POINT_COUNT; i++) begin
               if ($urandom_range(0, 19) == 0)
                  push_touch(ACT_SAMPLE, $urandom_range(0, RAW_MAX),
                             $urandom_range(0, RAW_MAX), 0);
               if ($urandom_range(0, 39) == 0)
                  push_touch(ACT_RESTART, $urandom_range(0, RAW_MAX),
                             $urandom_range(0, RAW_MAX), $urandom_range(0, 255));
               if (flip_axes) tap_target(ay[i], ax[i], jit);
               else tap_target(ax[i], ay[i], jit);
            end
            tmp = $urandom_range(12, 28);
            for (k = 0; k < tmp; k++) begin
               push_touch(ACT_SAMPLE, $urandom_range(0, RAW_MAX), $urandom_range(0, RAW_MAX),
                          ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 255));
            end
         end

         // Hold back new input until every outstanding transaction has come back.
         while (touch_q.size() != 0 || req_valid || outcome_q.size() != 0) @(posedge clock);
         repeat (SETTLE_WAIT) @(posedge clock);
      end

      if (fault_count == 0) begin
         $display("tb_touch_calibrate_and_map OK");
      end else begin
         $display("tb_touch_calibrate_and_map NOT OK");
      end
      $finish;
   end

endmodule
